// File: rtl/retransmit_duplicate_filter_top_macros.svh
// Assertion macros for the checker file of the duplicate filter.
`ifndef RETRANSMIT_DUPLICATE_FILTER_TOP_MACROS_SVH
`define RETRANSMIT_DUPLICATE_FILTER_TOP_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent must hold.
`define RDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent must hold in the next cycle.
`define RDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rdf_pkg.sv
// Types and constants shared by the retransmit duplicate filter modules.
`default_nettype none
package rdf_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int KEY_W = 32;
	localparam int TID_W = 8;
	localparam int LEN_W = 8;
	localparam int EVT_W = 64;

	localparam logic [LEN_W-1:0] HEADER_BYTES   = 8'd9;
	localparam logic [LEN_W-1:0] SRC_MAX_RESET  = 8'd32;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TID_W-1:0] tid;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic go;
		logic len_ok;
	} req_t;

	typedef struct packed {
		logic valid;
		logic ok;
		logic fire;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

// File: rtl/retransmit_duplicate_filter_top.sv
// Top level of the retransmit duplicate filter: ports, length check, sender table and result register.
`default_nettype none
// Screens received event messages for retransmitted duplicates, one sender table entry per
// source address. A message is taken on a rising edge with start high and busy low; busy then
// stays high until the result has been produced. The length is checked against the kind at once
// (nine bytes for a legacy message, ten up to nine plus source_max_length for a message with
// source). A message of bad length goes straight to the finishing state and leaves the table
// alone. For a message of valid length the table memory is read one entry a cycle, in slot order,
// and the scan stops at the first entry whose address matches; after the last read data returns,
// the finishing state writes the table back and raises the result. The table memory has a single
// read port. The result (length_ok, fire_event, send_ack, event_out) is shown for exactly one
// cycle with done high, and the receiver cannot stall it: each such cycle is one transfer. A new
// message may be started in the very cycle that done is high. An unknown sender is added; once
// the table is full the oldest inserted entry is replaced, as a ring. The table needs no clearing
// after reset, since only entries counted as filled are ever read. source_max_length is written
// through cfg_wr_en and cfg_wr_data and resets to 32; the user must write it only while busy is
// low, which the block itself does not enforce.
module retransmit_duplicate_filter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [7:0]  payload_length,
	input  wire logic [7:0]  transmission_id,
	input  wire logic [63:0] event_id,
	input  wire logic [31:0] sender_address,
	input  wire logic        cfg_wr_en,
	input  wire logic [7:0]  cfg_wr_data,
	output logic             done,
	output logic             length_ok,
	output logic             fire_event,
	output logic             send_ack,
	output logic [63:0]      event_out
);

	// Configuration register holding the largest accepted source length.
	logic [rdf_pkg::LEN_W-1:0] src_max_q;

	// Message fields held for the whole scan.
	rdf_pkg::entry_t           item_q;
	logic [rdf_pkg::EVT_W-1:0] event_q;

	// Result registers.
	logic                      done_q;
	logic                      length_ok_q;
	logic                      fire_q;
	logic [rdf_pkg::EVT_W-1:0] event_out_q;

	rdf_pkg::req_t   req;
	rdf_pkg::res_t   res;
	rdf_pkg::entry_t rd_data;
	rdf_pkg::entry_t wr_data;
	logic            rd_en;
	logic            wr_en;
	logic [rdf_pkg::IDX_W-1:0] rd_addr;
	logic [rdf_pkg::IDX_W-1:0] wr_addr;

	logic                      accept;
	logic                      len_ok;
	logic [rdf_pkg::LEN_W:0]   len_limit;

	assign accept = start && !busy;

	// The upper bound is formed one bit wider so that it never wraps.
	assign len_limit = {1'b0, rdf_pkg::HEADER_BYTES} + {1'b0, src_max_q};

	always_comb begin
		if (kind) begin
			len_ok = (payload_length > rdf_pkg::HEADER_BYTES) &&
			         ({1'b0, payload_length} <= len_limit);
		end else begin
			len_ok = (payload_length == rdf_pkg::HEADER_BYTES);
		end
	end

	assign req.go     = accept;
	assign req.len_ok = len_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_max_q <= rdf_pkg::SRC_MAX_RESET;
			done_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				src_max_q <= cfg_wr_data;
			end
			done_q <= res.valid;
		end
	end

	// Capture the message on acceptance; register the result when the sequencer finishes.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.key <= sender_address;
			item_q.tid <= transmission_id;
			event_q    <= event_id;
		end
		if (res.valid) begin
			length_ok_q <= res.ok;
			fire_q      <= res.fire;
			event_out_q <= res.ok ? event_q : '0;
		end
	end

	rdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.item    (item_q),
		.rd_data (rd_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (busy),
		.res     (res)
	);

	// Sender table: address and last transmission id in one word per entry.
	rdf_ram #(
		.WIDTH (rdf_pkg::ENTRY_W),
		.DEPTH (rdf_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign done       = done_q;
	assign length_ok  = length_ok_q;
	assign send_ack   = length_ok_q;
	assign fire_event = fire_q;
	assign event_out  = event_out_q;

endmodule
`default_nettype wire

// File: rtl/rdf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module rdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/rdf_ctrl.sv
// Sequencer that scans the sender table, decides on a new message and writes the table back.
`default_nettype none
module rdf_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rdf_pkg::req_t             req,
	input  wire rdf_pkg::entry_t           item,
	input  wire rdf_pkg::entry_t           rd_data,
	output logic                           rd_en,
	output logic [rdf_pkg::IDX_W-1:0]      rd_addr,
	output logic                           wr_en,
	output logic [rdf_pkg::IDX_W-1:0]      wr_addr,
	output rdf_pkg::entry_t                wr_data,
	output logic                           busy,
	output rdf_pkg::res_t                  res
);

	rdf_pkg::state_t state_q, state_d;

	logic [rdf_pkg::CNT_W-1:0] rd_idx_q;
	logic [rdf_pkg::CNT_W-1:0] entry_count_q;
	logic [rdf_pkg::IDX_W-1:0] oldest_q;
	logic [rdf_pkg::IDX_W-1:0] hit_idx_q;
	logic [rdf_pkg::IDX_W-1:0] cmp_idx_s1;
	logic                      cmp_vld_s1;
	logic                      cmp_last_s1;
	logic                      ok_q;
	logic                      miss_q;
	logic                      id_match_q;

	logic issue;
	logic key_hit;
	logic scan_miss;
	logic need_write;
	logic table_full;
	logic table_empty;

	assign issue       = (state_q == rdf_pkg::ST_SCAN) && (rd_idx_q < entry_count_q);
	assign key_hit     = cmp_vld_s1 && (rd_data.key == item.key);
	assign scan_miss   = cmp_vld_s1 && !key_hit && cmp_last_s1;
	assign need_write  = ok_q && (miss_q || !id_match_q);
	assign table_full  = (entry_count_q == rdf_pkg::CNT_W'(rdf_pkg::TABLE_DEPTH));
	assign table_empty = (entry_count_q == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rdf_pkg::ST_IDLE: begin
				if (req.go) begin
					if (!req.len_ok || table_empty) begin
						state_d = rdf_pkg::ST_FINISH;
					end else begin
						state_d = rdf_pkg::ST_SCAN;
					end
				end
			end
			rdf_pkg::ST_SCAN: begin
				if (key_hit || scan_miss) begin
					state_d = rdf_pkg::ST_FINISH;
				end
			end
			rdf_pkg::ST_FINISH: begin
				state_d = rdf_pkg::ST_IDLE;
			end
			default: begin
				state_d = rdf_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		rd_en     = issue;
		rd_addr   = rd_idx_q[rdf_pkg::IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = hit_idx_q;
		wr_data   = item;
		busy      = 1'b1;
		res.valid = 1'b0;
		res.ok    = ok_q;
		res.fire  = need_write;
		case (state_q)
			rdf_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			rdf_pkg::ST_SCAN: begin
				busy = 1'b1;
			end
			rdf_pkg::ST_FINISH: begin
				wr_en     = need_write;
				res.valid = 1'b1;
				if (miss_q) begin
					wr_addr = table_full ? oldest_q : entry_count_q[rdf_pkg::IDX_W-1:0];
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rdf_pkg::ST_IDLE;
			entry_count_q <= '0;
			oldest_q      <= '0;
			cmp_vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rdf_pkg::ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
				end
				rdf_pkg::ST_SCAN: begin
					cmp_vld_s1 <= issue;
				end
				rdf_pkg::ST_FINISH: begin
					cmp_vld_s1 <= 1'b0;
					if (need_write && miss_q) begin
						if (!table_full) begin
							entry_count_q <= entry_count_q + 1'b1;
						end else if (oldest_q == rdf_pkg::IDX_W'(rdf_pkg::TABLE_DEPTH - 1)) begin
							oldest_q <= '0;
						end else begin
							oldest_q <= oldest_q + 1'b1;
						end
					end
				end
				default: begin
					cmp_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Scan pointer, compare stage and decision flags.
	always_ff @(posedge clk) begin
		if (state_q == rdf_pkg::ST_IDLE && req.go) begin
			ok_q       <= req.len_ok;
			miss_q     <= table_empty;
			id_match_q <= 1'b0;
			rd_idx_q   <= '0;
		end else if (state_q == rdf_pkg::ST_SCAN) begin
			cmp_idx_s1  <= rd_idx_q[rdf_pkg::IDX_W-1:0];
			cmp_last_s1 <= (rd_idx_q == entry_count_q - 1'b1);
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (key_hit) begin
				hit_idx_q  <= cmp_idx_s1;
				id_match_q <= (rd_data.tid == item.tid);
				miss_q     <= 1'b0;
			end else if (scan_miss) begin
				miss_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rdf_checker.sv
// Port-level checker for the retransmit duplicate filter, bound to the top level.
`default_nettype none
`include "retransmit_duplicate_filter_top_macros.svh"
module rdf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        length_ok,
	input wire logic        fire_event,
	input wire logic        send_ack,
	input wire logic [63:0] event_out
);

	// An accepted message keeps the block busy in the following cycle.
	`RDF_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	// A result only ever follows a busy cycle.
	`RDF_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy), "result without work")

	// The acknowledgement follows the length check.
	`RDF_ASSERT_IMP(a_ack_eq_ok, clk, arst_n, done, send_ack == length_ok, "ack differs from length_ok")

	// A rejected message neither fires nor echoes its event.
	`RDF_ASSERT_IMP(a_bad_len_quiet, clk, arst_n, done && !length_ok,
		!fire_event && (event_out == 64'd0), "bad length produced output")

endmodule

bind retransmit_duplicate_filter_top rdf_checker u_rdf_checker (.*);
`default_nettype wire

// File: verif/rdf_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class for the duplicate filter: sender table predictor and the result store.
package rdf_tb_pkg;

	import rdf_pkg::*;

	typedef struct packed {
		logic        length_ok;
		logic        fire_event;
		logic        send_ack;
		logic [63:0] event_out;
	} verdict_t;

	class filter_scoreboard;
		bit [KEY_W-1:0] sender_tab [TABLE_DEPTH];
		bit [TID_W-1:0] tid_tab [TABLE_DEPTH];
		int unsigned    filled;
		int unsigned    ring_pos;
		bit [LEN_W-1:0] src_limit;
		verdict_t       pending_verdicts[$];
		int unsigned    errors;
		int unsigned    messages;
		int unsigned    fired;
		int unsigned    duplicates;
		int unsigned    rejected;
		int unsigned    evictions;
		int unsigned    limit_writes;

		function new();
			src_limit = SRC_MAX_RESET;
		endfunction

		function void write_limit(bit [LEN_W-1:0] value);
			src_limit = value;
			limit_writes++;
		endfunction

		// Works out the verdict of one accepted message and updates the table copy.
		function void note_message(bit kind, bit [LEN_W-1:0] len, bit [TID_W-1:0] tid,
				bit [EVT_W-1:0] evt, bit [KEY_W-1:0] addr);
			verdict_t v;
			bit       ok;
			bit       found;
			int       hit;
			int       slot;

			v = '0;
			found = 0;
			hit = 0;
			if (kind == 1'b0) begin
				ok = (len == HEADER_BYTES);
			end else begin
				ok = (len > HEADER_BYTES) &&
					(int'(len) <= int'(HEADER_BYTES) + int'(src_limit));
			end
			messages++;
			if (ok) begin
				for (int i = 0; i < int'(filled); i++) begin
					if (!found && sender_tab[i] == addr) begin
						found = 1;
						hit = i;
					end
				end
				if (!found) begin
					v.fire_event = 1'b1;
					if (filled < TABLE_DEPTH) begin
						sender_tab[filled] = addr;
						tid_tab[filled] = tid;
						filled++;
					end else begin
						slot = ring_pos % TABLE_DEPTH;
						sender_tab[slot] = addr;
						tid_tab[slot] = tid;
						ring_pos = (slot + 1) % TABLE_DEPTH;
						evictions++;
					end
				end else if (tid_tab[hit] != tid) begin
					v.fire_event = 1'b1;
					tid_tab[hit] = tid;
				end
				if (v.fire_event)
					fired++;
				else
					duplicates++;
				v.length_ok = 1'b1;
				v.send_ack = 1'b1;
				v.event_out = evt;
			end else begin
				rejected++;
			end
			pending_verdicts = {pending_verdicts, v};
		endfunction

		// Compares one result transfer with the oldest outstanding verdict.
		function void check_verdict(bit ok, bit fire, bit ack, bit [EVT_W-1:0] evt);
			verdict_t want;

			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: result transfer with no message outstanding (event_out %h)",
					$time, evt);
				return;
			end
			want = pending_verdicts.pop_front();
			if (ok !== want.length_ok) begin
				errors++;
				$display("%0t: length_ok expected %b, got %b", $time, want.length_ok, ok);
			end
			if (fire !== want.fire_event) begin
				errors++;
				$display("%0t: fire_event expected %b, got %b", $time, want.fire_event, fire);
			end
			if (ack !== want.send_ack) begin
				errors++;
				$display("%0t: send_ack expected %b, got %b", $time, want.send_ack, ack);
			end
			if (evt !== want.event_out) begin
				errors++;
				$display("%0t: event_out expected %h, got %h", $time, want.event_out, evt);
			end
		endfunction
	endclass

endpackage

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the retransmit duplicate filter: stimulus, monitor and final verdict.
module tb;

	import rdf_pkg::*;
	import rdf_tb_pkg::*;

	localparam int POOL_SIZE = 44;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [7:0]  payload_length;
	logic [7:0]  transmission_id;
	logic [63:0] event_id;
	logic [31:0] sender_address;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        done;
	logic        length_ok;
	logic        fire_event;
	logic        send_ack;
	logic [63:0] event_out;

	filter_scoreboard sb;

	// The limit the stimulus currently believes in; it steers the lengths of well-formed
	// messages towards the accepted window.
	bit [7:0]  cur_limit;
	// More addresses than table entries, so that the ring replacement is exercised all the time
	// and evicted senders come back as new ones.
	bit [31:0] addr_pool [POOL_SIZE];

	retransmit_duplicate_filter_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.payload_length  (payload_length),
		.transmission_id (transmission_id),
		.event_id        (event_id),
		.sender_address  (sender_address),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.done            (done),
		.length_ok       (length_ok),
		.fire_event      (fire_event),
		.send_ack        (send_ack),
		.event_out       (event_out)
	);

	always #2 clk = ~clk;

	// Monitor. Everything is sampled at the rising edge, before the block's own updates land,
	// and the inputs only ever move at the falling edge, so the order of events cannot matter.
	// A result is checked before a message accepted on the same edge is noted, since that result
	// always belongs to an earlier message.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_verdict(length_ok, fire_event, send_ack, event_out);
			if (start && !busy)
				sb.note_message(kind, payload_length, transmission_id, event_id,
					sender_address);
			if (cfg_wr_en)
				sb.write_limit(cfg_wr_data);
		end
	end

	// Presents one message from the next falling edge and holds it until the block accepts it.
	task automatic drive_message(input bit k, input bit [7:0] len, input bit [7:0] tid,
			input bit [63:0] evt, input bit [31:0] addr);
		@(negedge clk);
		start = 1'b1;
		kind = k;
		payload_length = len;
		transmission_id = tid;
		event_id = evt;
		sender_address = addr;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Idle cycles with start low; the payload ports carry rubbish meanwhile, which must be ignored.
	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start = 1'b0;
			kind = 1'($urandom);
			payload_length = 8'($urandom);
			transmission_id = 8'($urandom);
			event_id = {$urandom, $urandom};
			sender_address = $urandom;
			@(posedge clk);
		end
	endtask

	// Holds the sender off until every outstanding result has arrived.
	task automatic wait_until_quiet();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// The limit is only changed while the block is idle and nothing is outstanding.
	task automatic write_source_limit(input bit [7:0] value);
		wait_until_quiet();
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		cur_limit = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'($urandom);
	endtask

	// Most messages are well formed and come from the address pool with a small spread of
	// transmission ids, so that duplicates, id updates and ring evictions are all frequent. The
	// rest is noise with every field at random.
	task automatic send_random_message();
		bit         k;
		bit [7:0]   len;
		bit [7:0]   tid;
		bit [31:0]  addr;
		int         upper;

		if ($urandom_range(99) < 75) begin
			k = (cur_limit == 0) ? 1'b0 : 1'($urandom);
			upper = 9 + int'(cur_limit);
			if (upper > 255)
				upper = 255;
			len = k ? 8'($urandom_range(upper, 10)) : HEADER_BYTES;
			addr = ($urandom_range(99) < 90) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
				: $urandom;
			tid = ($urandom_range(1) == 0) ? 8'($urandom_range(2)) : 8'($urandom);
		end else begin
			k = 1'($urandom);
			len = 8'($urandom);
			addr = ($urandom_range(1) == 0) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
				: $urandom;
			tid = 8'($urandom);
		end
		drive_message(k, len, tid, {$urandom, $urandom}, addr);
	endtask

	task automatic run_phase(input int count, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			sender_gap(idle_pct);
			send_random_message();
			// Half way through, the sender waits for the pipeline to drain completely.
			if (i == count / 2)
				wait_until_quiet();
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = 1'b0;
		payload_length = '0;
		transmission_id = '0;
		event_id = '0;
		sender_address = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cur_limit = SRC_MAX_RESET;
		sb = new();
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		addr_pool[0] = '0;
		addr_pool[1] = '1;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, first with the limit at its reset value of 32. A new sender, a
		// duplicate, an id update, then lengths either side of each boundary for both kinds.
		drive_message(1'b0, 8'd9, 8'h00, 64'h0, 32'h0);
		drive_message(1'b0, 8'd9, 8'h00, '1, 32'h0);
		drive_message(1'b0, 8'd9, 8'hff, 64'h0123_4567_89ab_cdef, 32'h0);
		drive_message(1'b0, 8'd8, 8'h11, '1, 32'h0);
		drive_message(1'b0, 8'd10, 8'h22, '1, 32'h0);
		drive_message(1'b1, 8'd9, 8'h33, '1, '1);
		drive_message(1'b1, 8'd10, 8'hff, '1, '1);
		drive_message(1'b1, 8'd41, 8'hff, 64'h8000_0000_0000_0001, '1);
		drive_message(1'b1, 8'd42, 8'h00, '1, '1);
		drive_message(1'b1, 8'd0, 8'h00, '1, 32'h1234_5678);
		drive_message(1'b1, 8'd255, 8'h00, '1, 32'h1234_5678);
		drive_message(1'b0, 8'd255, 8'h00, '1, 32'h1234_5678);
		drive_message(1'b0, 8'd0, 8'h00, '1, 32'h1234_5678);

		// With the limit at zero nothing with source is accepted; legacy still is.
		write_source_limit(8'd0);
		drive_message(1'b1, 8'd10, 8'h44, '1, 32'h1234_5678);
		drive_message(1'b0, 8'd9, 8'h44, 64'hdead_beef_0000_0001, 32'h1234_5678);

		// Large limits: the upper bound must not wrap past 255.
		write_source_limit(8'd255);
		drive_message(1'b1, 8'd255, 8'h45, 64'h5555_aaaa_5555_aaaa, 32'h1234_5678);
		drive_message(1'b1, 8'd10, 8'h45, 64'haaaa_5555_aaaa_5555, 32'h1234_5678);
		write_source_limit(8'd247);
		drive_message(1'b1, 8'd255, 8'h46, '1, 32'h8765_4321);
		write_source_limit(8'd246);
		drive_message(1'b1, 8'd255, 8'h47, '1, 32'h8765_4321);
		drive_message(1'b1, 8'd254, 8'h47, '1, 32'h8765_4321);
		write_source_limit(8'd1);
		drive_message(1'b1, 8'd10, 8'h48, '1, 32'h8765_4321);
		drive_message(1'b1, 8'd11, 8'h49, '1, 32'h8765_4321);

		// Random part in three phases: light sender idling, heavy sender idling, back to back.
		write_source_limit(8'd246);
		run_phase(380, 10);
		write_source_limit(8'($urandom_range(245, 2)));
		run_phase(380, 75);
		write_source_limit(8'd1);
		run_phase(390, 0);

		wait_until_quiet();
		repeat (40) @(posedge clk);

		$display("Checked %0d messages over %0d limit settings: %0d fired, %0d duplicates,",
			sb.messages, sb.limit_writes + 1, sb.fired, sb.duplicates);
		$display("%0d rejected for length and %0d senders evicted from the full table.",
			sb.rejected, sb.evictions);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
			$display("retransmit_duplicate_filter_top test passed");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.errors,
				sb.pending_verdicts.size());
			$display("retransmit_duplicate_filter_top test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4ms;
		$display("retransmit_duplicate_filter_top test failed");
		$finish;
	end

endmodule
